// File: rtl/dogc_pkg.sv
// Shared types and codes for the degree-ordered greedy coloring block.
`timescale 1ns / 1ps

package dogc_pkg;

  // Operation codes carried by the func field
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_COLOR = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_B,
    ST_E_WA,
    ST_E_WB,
    ST_DEG_RD,
    ST_DEG_SUM,
    ST_DEG_WR,
    ST_SRT_RD,
    ST_SRT_CMP,
    ST_COL_INIT,
    ST_COL_ORD,
    ST_COL_V,
    ST_COL_CHK,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  // Source of the adjacency read address
  typedef enum logic [1:0] {
    ADJ_SEL_IN,
    ADJ_SEL_B,
    ADJ_SEL_IDX,
    ADJ_SEL_ORD
  } adj_sel_t;

  typedef struct packed {
    adj_sel_t adj_sel;
    logic     latch_ab;
    logic     clr_graph;
    logic     start;
    logic     cap_rowa;
    logic     cap_rowb;
    logic     wr_rowa;
    logic     wr_rowb;
    logic     deg_sum;
    logic     deg_wr;
    logic     srt_cmp;
    logic     col_init;
    logic     col_skip;
    logic     col_chk;
    logic     em_load;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic dup;
    logic idx_last;
    logic col_done;
    logic v_colored;
    logic srt_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/dogc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dogc_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and read one word each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dogc_ctrl.sv
// Controller state machine: sequences edge loads, degree count, sort, coloring passes and emission.
`timescale 1ns / 1ps

module dogc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         func,
  input  dogc_pkg::status_t  status,
  output logic               in_ready,
  output dogc_pkg::cmd_t     cmd
);
  import dogc_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FN_ADD:   state_next = status.edge_ok ? ST_E_B : ST_IDLE;
            FN_COLOR: state_next = ST_DEG_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_E_B:      state_next = ST_E_WA;
      ST_E_WA:     state_next = status.dup ? ST_IDLE : ST_E_WB;
      ST_E_WB:     state_next = ST_IDLE;
      ST_DEG_RD:   state_next = ST_DEG_SUM;
      ST_DEG_SUM:  state_next = ST_DEG_WR;
      ST_DEG_WR:   state_next = status.idx_last ? ST_SRT_RD : ST_DEG_RD;
      ST_SRT_RD:   state_next = ST_SRT_CMP;
      ST_SRT_CMP:  state_next = status.srt_done ? ST_COL_INIT : ST_SRT_RD;
      ST_COL_INIT: state_next = ST_COL_ORD;
      ST_COL_ORD:  state_next = ST_COL_V;
      ST_COL_V: begin
        if (status.v_colored) begin
          state_next = (status.idx_last && status.col_done) ? ST_EM_RD : ST_COL_ORD;
        end else begin
          state_next = ST_COL_CHK;
        end
      end
      ST_COL_CHK:  state_next = (status.idx_last && status.col_done) ? ST_EM_RD : ST_COL_ORD;
      ST_EM_RD:    state_next = ST_EM_LD;
      ST_EM_LD: begin
        if (status.out_free) begin
          state_next = status.idx_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd         = '0;
    cmd.adj_sel = ADJ_SEL_IN;
    unique case (state)
      ST_IDLE: begin
        cmd.latch_ab  = accept;
        cmd.clr_graph = accept && (func == FN_CLEAR);
        cmd.start     = accept && (func == FN_COLOR);
      end
      ST_E_B: begin
        cmd.adj_sel  = ADJ_SEL_B;
        cmd.cap_rowa = 1'b1;
      end
      ST_E_WA: begin
        cmd.cap_rowb = 1'b1;
        cmd.wr_rowa  = !status.dup;
      end
      ST_E_WB:     cmd.wr_rowb = 1'b1;
      ST_DEG_RD:   cmd.adj_sel = ADJ_SEL_IDX;
      ST_DEG_SUM:  cmd.deg_sum = 1'b1;
      ST_DEG_WR:   cmd.deg_wr = 1'b1;
      ST_SRT_RD:   cmd.srt_cmp = 1'b0;
      ST_SRT_CMP:  cmd.srt_cmp = 1'b1;
      ST_COL_INIT: cmd.col_init = 1'b1;
      ST_COL_ORD:  cmd.col_init = 1'b0;
      ST_COL_V: begin
        cmd.adj_sel  = ADJ_SEL_ORD;
        cmd.col_skip = status.v_colored;
      end
      ST_COL_CHK:  cmd.col_chk = 1'b1;
      ST_EM_RD:    cmd.em_load = 1'b0;
      ST_EM_LD:    cmd.em_load = status.out_free;
      default:     cmd.em_load = 1'b0;
    endcase
  end

endmodule

// File: rtl/dogc_dp.sv
// Datapath: adjacency store, degree count, sorted order, coloring masks and result register.
`timescale 1ns / 1ps

module dogc_dp #(
  parameter int NV = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        vertex_a,
  input  logic [5:0]        vertex_b,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  input  dogc_pkg::cmd_t    cmd,
  output dogc_pkg::status_t status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [5:0]        vertex,
  output logic [6:0]        color,
  output logic [6:0]        num_colors,
  output logic              last
);
  import dogc_pkg::*;

  localparam int IW  = $clog2(NV);
  localparam int CW  = $clog2(NV + 1);
  localparam int NCH = (NV + 7) / 8;
  localparam logic [6:0]    NV7   = 7'(NV);
  localparam logic [CW-1:0] D_TOP = CW'(NV - 1);

  logic [6:0]    nv_reg;
  logic [6:0]    n7;
  logic [CW-1:0] n;
  logic [CW-1:0] n_m1;
  logic [NV-1:0] act;

  logic [IW-1:0] ra, rb;
  logic [NV-1:0] rowa, rowb;
  logic [NV-1:0] adj_vld;
  logic          adj_vld_q;
  logic [NV-1:0] adj_rdata, adj_row, adj_wdata;
  logic [IW-1:0] adj_raddr, adj_waddr;
  logic          adj_we;

  logic [CW-1:0] idx, wp, d, c;
  logic [IW-1:0] v_reg;
  logic [NV-1:0] colored, cls, colored_next;
  logic          clash, assign_v, adv, match;

  logic [3:0]    part [NCH];
  logic [3:0]    part_c [NCH];
  logic [NCH*8-1:0] row_pad;
  logic [6:0]    deg_sum;

  logic [CW-1:0] deg_rdata;
  logic [IW-1:0] ord_rdata;
  logic [CW-1:0] col_rdata;

  // Effective vertex count, saturated to the storage size, with zero taken as one
  always_comb begin
    if (nv_reg == 7'd0) begin
      n7 = 7'd1;
    end else if (nv_reg > NV7) begin
      n7 = NV7;
    end else begin
      n7 = nv_reg;
    end
  end
  assign n    = CW'(n7);
  assign n_m1 = n - 1'b1;

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      act[k] = (k < int'(n));
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      nv_reg <= 7'd64;
    end else if (cfg_we) begin
      nv_reg <= cfg_data;
    end
  end

  // Adjacency read address
  always_comb begin
    case (cmd.adj_sel)
      ADJ_SEL_IN:  adj_raddr = vertex_a[IW-1:0];
      ADJ_SEL_B:   adj_raddr = rb;
      ADJ_SEL_IDX: adj_raddr = idx[IW-1:0];
      default:     adj_raddr = ord_rdata;
    endcase
  end

  assign adj_we    = cmd.wr_rowa || cmd.wr_rowb;
  assign adj_waddr = cmd.wr_rowa ? ra : rb;
  assign adj_wdata = cmd.wr_rowa ? (rowa | (NV'(1) << rb)) : (rowb | (NV'(1) << ra));
  assign adj_row   = adj_vld_q ? adj_rdata : '0;

  dogc_ram #(.W(NV), .D(NV)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Row valid bits: a row never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      adj_vld <= '0;
    end else if (cmd.clr_graph) begin
      adj_vld <= '0;
    end else if (adj_we) begin
      adj_vld[adj_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    adj_vld_q <= adj_vld[adj_raddr];
  end

  // Latch endpoints and rows for an edge insert
  always_ff @(posedge clk) begin
    if (cmd.latch_ab) begin
      ra <= vertex_a[IW-1:0];
      rb <= vertex_b[IW-1:0];
    end
    if (cmd.cap_rowa) begin
      rowa <= adj_row;
    end
    if (cmd.cap_rowb) begin
      rowb <= adj_row;
    end
  end

  // Degree popcount: chunk counts first, then their sum
  always_comb begin
    row_pad = (NCH*8)'(adj_row);
    for (int ch = 0; ch < NCH; ch++) begin
      part_c[ch] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        part_c[ch] = part_c[ch] + 4'(row_pad[ch*8 + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deg_sum) begin
      for (int ch = 0; ch < NCH; ch++) begin
        part[ch] <= part_c[ch];
      end
    end
  end

  always_comb begin
    deg_sum = 7'd0;
    for (int ch = 0; ch < NCH; ch++) begin
      deg_sum = deg_sum + 7'(part[ch]);
    end
  end

  dogc_ram #(.W(CW), .D(NV)) u_deg (
    .clk   (clk),
    .we    (cmd.deg_wr),
    .waddr (idx[IW-1:0]),
    .wdata (CW'(deg_sum)),
    .raddr (idx[IW-1:0]),
    .rdata (deg_rdata)
  );

  // Order store, filled by the degree scan
  assign match = (deg_rdata == d);

  dogc_ram #(.W(IW), .D(NV)) u_ord (
    .clk   (clk),
    .we    (cmd.srt_cmp && match),
    .waddr (wp[IW-1:0]),
    .wdata (idx[IW-1:0]),
    .raddr (idx[IW-1:0]),
    .rdata (ord_rdata)
  );

  // Coloring checks against the current color class
  assign clash        = |(adj_row & cls);
  assign assign_v     = cmd.col_chk && !clash;
  assign colored_next = colored | (assign_v ? (NV'(1) << v_reg) : '0);
  assign adv          = cmd.col_skip || cmd.col_chk;

  dogc_ram #(.W(CW), .D(NV)) u_col (
    .clk   (clk),
    .we    (assign_v),
    .waddr (v_reg),
    .wdata (c),
    .raddr (idx[IW-1:0]),
    .rdata (col_rdata)
  );

  // Advance counters and masks
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.deg_wr) begin
      if (idx == n_m1) begin
        idx <= '0;
        d   <= D_TOP;
        wp  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end else if (cmd.srt_cmp) begin
      if (match) begin
        wp <= wp + 1'b1;
      end
      if (idx == n_m1) begin
        idx <= '0;
        d   <= d - 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end else if (cmd.col_init) begin
      idx     <= '0;
      c       <= CW'(1);
      colored <= '0;
      cls     <= '0;
    end else if (adv) begin
      colored <= colored_next;
      if (idx == n_m1) begin
        idx <= '0;
        if (!status.col_done) begin
          c   <= c + 1'b1;
          cls <= '0;
        end else if (assign_v) begin
          cls[v_reg] <= 1'b1;
        end
      end else begin
        idx <= idx + 1'b1;
        if (assign_v) begin
          cls[v_reg] <= 1'b1;
        end
      end
    end else if (cmd.em_load) begin
      idx <= idx + 1'b1;
    end
    if (cmd.col_skip || (cmd.adj_sel == ADJ_SEL_ORD)) begin
      v_reg <= ord_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.em_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      vertex     <= 6'(idx[IW-1:0]);
      color      <= 7'(col_rdata);
      num_colors <= 7'(c);
      last       <= (idx == n_m1);
    end
  end

  // Status back to the controller
  assign status.edge_ok   = (vertex_a != vertex_b) && ({1'b0, vertex_a} < n7)
                            && ({1'b0, vertex_b} < n7);
  assign status.dup       = rowa[rb];
  assign status.idx_last  = (idx == n_m1);
  assign status.col_done  = &(colored_next | ~act);
  assign status.v_colored = colored[ord_rdata];
  assign status.srt_done  = match && (wp == n_m1);
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: rtl/degree_ordered_greedy_coloring.sv
// Top level of the degree-ordered greedy graph coloring block.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_ready  | func, vertex_a, vertex_b
//  output  | out_valid/out_ready  | vertex, color, num_colors, last
//  config  | cfg_we               | cfg_data (num_vertices)
//
//  An add transaction reads both adjacency rows, then writes them in turn through the
//  single write port; a duplicate one writes neither, a rejected or clear one is done
//  on acceptance. A color transaction reads, sums and writes each degree, fills the
//  order by comparing every vertex per degree from NV-1 down, starts coloring, gives
//  each vertex an order read and colored test (and a clash check if uncolored) per
//  pass, then emits each result, held by output stalls. Reset clears row valid bits
//  at once, no clearing pass. The input stalls for the whole color run; the last
//  result may wait in the output register while the next transaction is taken.

module degree_ordered_greedy_coloring #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [5:0] vertex_a,
  input  logic [5:0] vertex_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] vertex,
  output logic [6:0] color,
  output logic [6:0] num_colors,
  output logic       last,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);
  import dogc_pkg::*;

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  cmd_t    cmd;
  status_t status;

  dogc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dogc_dp #(.NV(NV)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .vertex     (vertex),
    .color      (color),
    .num_colors (num_colors),
    .last       (last)
  );

endmodule

// File: tb/degree_ordered_greedy_coloring_tb.sv
// Testbench for the degree-ordered greedy coloring block: directed and random graphs.
`timescale 1ns / 1ps

module degree_ordered_greedy_coloring_tb;
  import dogc_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [5:0] vertex;
    logic [6:0] color;
    logic [6:0] num_colors;
    logic       last;
  } coloring_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FN_ADD;
  logic [5:0] vertex_a = '0;
  logic [5:0] vertex_b = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] vertex;
  logic [6:0] color;
  logic [6:0] num_colors;
  logic       last;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  // Shadow graph and configuration
  logic       adj [64][64];
  logic [6:0] deg [64];
  logic [6:0] vcount_reg;
  coloring_t  pending_colorings [$];
  int         errors = 0;
  int         results_seen = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  bit         stall_enable = 1'b1;

  degree_ordered_greedy_coloring #(.MAX_VERTICES(64)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .vertex_a(vertex_a), .vertex_b(vertex_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex(vertex), .color(color), .num_colors(num_colors), .last(last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int active_vertices();
    int n;
    n = int'(vcount_reg);
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < 64; i++) begin
      deg[i] = '0;
      for (int j = 0; j < 64; j++) adj[i][j] = 1'b0;
    end
  endfunction

  // Sort by degree, color greedily, queue one result per vertex
  function automatic void predict_coloring();
    int n, used, c, order [64], col [64], t;
    bit pending, swapped, clash;
    n = active_vertices();
    for (int j = 0; j < n; j++) order[j] = j;
    for (int p = 0; p < n; p++) begin
      swapped = 0;
      for (int j = 0; j + 1 < n; j++) begin
        if (deg[order[j]] < deg[order[j+1]]) begin
          t = order[j]; order[j] = order[j+1]; order[j+1] = t; swapped = 1;
        end
      end
      if (!swapped) break;
    end
    for (int i = 0; i < n; i++) col[i] = 0;
    c = 0;
    pending = 1;
    while (pending) begin
      pending = 0;
      c++;
      for (int i = 0; i < n; i++) begin
        if (col[order[i]] == 0) begin
          pending = 1;
          clash = 0;
          for (int k = 0; k < n; k++)
            if (adj[order[i]][k] && col[k] == c) clash = 1;
          if (!clash) col[order[i]] = c;
        end
      end
    end
    used = c - 1;
    for (int i = 0; i < n; i++)
      pending_colorings.push_back({6'(i), 7'(col[i]), 7'(used), 1'(i + 1 == n)});
  endfunction

  function automatic void predict_item(logic [1:0] f, logic [5:0] a, logic [5:0] b);
    int n;
    n = active_vertices();
    if (f == FN_ADD) begin
      if (a != b && a < n && b < n && !adj[a][b]) begin
        adj[a][b] = 1'b1; adj[b][a] = 1'b1;
        deg[a] = deg[a] + 7'd1; deg[b] = deg[b] + 7'd1;
      end
    end else if (f == FN_CLEAR) begin
      clear_graph();
    end else if (f == FN_COLOR) begin
      predict_coloring();
    end
  endfunction

  // Send one transaction, with bursty gaps on the sender side
  task automatic send_item(logic [1:0] f, logic [5:0] a, logic [5:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f; vertex_a <= a; vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    predict_item(f, a, b);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_colorings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [6:0] value);
    wait_drained();
    cfg_we <= 1'b1; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_reg = value;
  endtask

  task automatic add_edge(int a, int b);
    send_item(FN_ADD, 6'(a), 6'(b));
  endtask

  task automatic test_empty_and_full_graph();
    write_vertex_count(7'd4);
    send_item(FN_COLOR, '0, '0);
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++) add_edge(i, j);
    send_item(FN_COLOR, '0, '0);
  endtask

  // Self-loop, duplicate, out-of-range endpoint, unused func, clear
  task automatic test_ignored_items();
    write_vertex_count(7'd6);
    send_item(FN_CLEAR, '0, '0);
    add_edge(2, 2);
    add_edge(0, 5);
    add_edge(5, 0);
    add_edge(0, 6);
    add_edge(63, 1);
    send_item(2'd3, 6'h3f, 6'h3f);
    add_edge(1, 2);
    send_item(FN_COLOR, '0, '0);
    send_item(FN_CLEAR, '0, '0);
    send_item(FN_COLOR, '0, '0);
  endtask

  // Edges that survive a lower vertex count still weigh in the order
  task automatic test_count_extremes();
    write_vertex_count(7'd64);
    send_item(FN_CLEAR, '0, '0);
    add_edge(0, 63);
    add_edge(62, 63);
    add_edge(1, 40);
    add_edge(40, 2);
    send_item(FN_COLOR, '0, '0);
    write_vertex_count(7'd3);
    send_item(FN_COLOR, '0, '0);
    write_vertex_count(7'd0);
    send_item(FN_COLOR, '0, '0);
    write_vertex_count(7'd127);
    send_item(FN_COLOR, '0, '0);
    write_vertex_count(7'd1);
    send_item(FN_COLOR, '0, '0);
  endtask

  // Mostly well-formed graphs: clear, load random edges, color
  task automatic test_random_graphs();
    int n, edges, r;
    int items = 0;
    while (items < 150) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
      write_vertex_count(7'(n));
      send_item(FN_CLEAR, '0, '0);
      edges = $urandom_range(0, (n < 12) ? n * 2 : 24);
      for (int e = 0; e < edges; e++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_item(2'($urandom_range(2, 3)), 6'($urandom), 6'($urandom));
        else if (r == 1) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
        else add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        items++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      send_item(FN_COLOR, '0, '0);
      items += 2;
    end
  endtask

  // Receiver stalls on its own pattern, with stretches of no stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !stall_enable || ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst && ($urandom_range(0, 499) == 0)) stall_enable <= ~stall_enable;
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    coloring_t exp_c;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_colorings.size() == 0) begin
        $error("unexpected result: vertex %0d color %0d", vertex, color);
        errors++;
      end else begin
        exp_c = pending_colorings.pop_front();
        if (vertex !== exp_c.vertex) begin
          $error("vertex: expected %0d, got %0d", exp_c.vertex, vertex); errors++;
        end
        if (color !== exp_c.color) begin
          $error("color: expected %0d, got %0d", exp_c.color, color); errors++;
        end
        if (num_colors !== exp_c.num_colors) begin
          $error("num_colors: expected %0d, got %0d", exp_c.num_colors, num_colors);
          errors++;
        end
        if (last !== exp_c.last) begin
          $error("last: expected %0d, got %0d", exp_c.last, last); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_graph();
    vcount_reg = 7'd64;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_full_graph();
    test_ignored_items();
    test_count_extremes();
    test_random_graphs();
    wait_drained();
    if (pending_colorings.size() != 0) errors++;
    $display("Covered edge loads, ignored edges, clears, and vertex counts 0 to 127;");
    $display("%0d vertex results checked.", results_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
